@@ rtl/core/escaped_crc8_frame_receiver_top_macros.svh @@
// assertion helpers for the frame receiver
`ifndef ESCAPED_CRC8_FRAME_RECEIVER_TOP_MACROS_SVH
`define ESCAPED_CRC8_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define ECFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ECFR_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ECFR_ASSERT(lbl, clk, rst, !(cond), msg)
`else
`define ECFR_ASSERT(lbl, clk, rst, prop, msg)
`define ECFR_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

@@ rtl/core/ecfr_pkg.sv @@
package ecfr_pkg;

   localparam int unsigned BUF_DEPTH = 64;
   localparam int unsigned FILL_W    = $clog2(BUF_DEPTH + 1);
   localparam int unsigned ADDR_W    = $clog2(BUF_DEPTH);
   localparam int unsigned MEM_AW    = ADDR_W + 1;
   localparam int unsigned MEM_DEPTH = 2 * BUF_DEPTH;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ESC_BYTE = 8'hDC;
   localparam logic [7:0] ESC_FLIP = 8'h80;
   localparam logic [7:0] EOL_BYTE = 8'h0A;
   localparam logic [FILL_W-1:0] MIN_FRAME = FILL_W'(3);

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_POLY  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_START = CSR_IDX_W'(1);
   localparam logic [7:0] POLY_RESET  = 8'h07;
   localparam logic [7:0] START_RESET = 8'h00;

   // one good frame handed from front to back
   typedef struct packed {
      logic              bank;
      logic [FILL_W-1:0] plen;
      logic [7:0]        ctr;
      logic [7:0]        fid;
   } desc_type;

   // frame store write port
   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        data;
   } wr_req_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [7:0]           data;
   } csr_wr_type;

   typedef struct packed {
      logic head_valid;
      logic full;
   } queue_status_type;

endpackage

@@ rtl/core/ecfr_front.sv @@
module ecfr_front
   import ecfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  csr_wr_type csr,
   output wr_req_type wr_req,
   output logic       push,
   output desc_type   push_desc
);

   logic [7:0]        poly_ff, poly_in;
   logic [7:0]        start_ff, start_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        crc_ff, crc_in;
   logic              esc_ff, esc_in;
   logic              discard_ff, discard_in;
   logic              bank_ff, bank_in;
   logic [7:0]        ctr_ff, ctr_in;
   logic [7:0]        fid_ff, fid_in;
   logic [7:0]        lit_byte;
   logic [7:0]        crc_seed;
   logic [7:0]        crc_next;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ poly;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

   assign lit_byte = esc_ff ? (rx_byte ^ ESC_FLIP) : rx_byte;
   assign crc_seed = (fill_ff == '0) ? start_ff : crc_ff;
   assign crc_next = crc8_step(crc_seed, lit_byte, poly_ff);

   assign push_desc.bank = bank_ff;
   assign push_desc.plen = fill_ff - MIN_FRAME;
   assign push_desc.ctr  = ctr_ff;
   assign push_desc.fid  = fid_ff;

   always_comb begin
      poly_in    = poly_ff;
      start_in   = start_ff;
      fill_in    = fill_ff;
      crc_in     = crc_ff;
      esc_in     = esc_ff;
      discard_in = discard_ff;
      bank_in    = bank_ff;
      ctr_in     = ctr_ff;
      fid_in     = fid_ff;
      push       = 1'b0;
      wr_req     = '0;

      if (csr.valid) begin
         case (csr.index)
            CSR_POLY:  poly_in  = csr.data;
            CSR_START: start_in = csr.data;
            default:   ;
         endcase
      end

      if (accept) begin
         if (discard_ff) begin
            // drop raw words up to the next raw newline
            if (rx_byte == EOL_BYTE) begin
               discard_in = 1'b0;
               fill_in    = '0;
               esc_in     = 1'b0;
            end
         end else if (!esc_ff && rx_byte == ESC_BYTE) begin
            esc_in = 1'b1;
         end else if (!esc_ff && rx_byte == EOL_BYTE) begin
            if (fill_ff >= MIN_FRAME && crc_ff == '0) begin
               push    = 1'b1;
               bank_in = ~bank_ff;
            end
            fill_in = '0;
            esc_in  = 1'b0;
         end else begin
            esc_in         = 1'b0;
            crc_in         = crc_next;
            wr_req.en      = 1'b1;
            wr_req.addr    = {bank_ff, fill_ff[ADDR_W-1:0]};
            wr_req.data    = lit_byte;
            if (fill_ff == FILL_W'(0)) begin
               ctr_in = lit_byte;
            end
            if (fill_ff == FILL_W'(1)) begin
               fid_in = lit_byte;
            end
            if (fill_ff == FILL_W'(BUF_DEPTH - 1)) begin
               fill_in    = '0;
               discard_in = 1'b1;
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff    <= POLY_RESET;
         start_ff   <= START_RESET;
         fill_ff    <= '0;
         crc_ff     <= START_RESET;
         esc_ff     <= 1'b0;
         discard_ff <= 1'b0;
         bank_ff    <= 1'b0;
      end else begin
         poly_ff    <= poly_in;
         start_ff   <= start_in;
         fill_ff    <= fill_in;
         crc_ff     <= crc_in;
         esc_ff     <= esc_in;
         discard_ff <= discard_in;
         bank_ff    <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in;
      fid_ff <= fid_in;
   end

endmodule

@@ rtl/core/ecfr_queue.sv @@
`include "escaped_crc8_frame_receiver_top_macros.svh"

module ecfr_queue
   import ecfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  desc_type         push_desc,
   input  logic             pop,
   output desc_type         head,
   output queue_status_type status
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   desc_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign head              = entry_ff[rd_ptr_ff];
   assign status.head_valid = (count_ff != '0);
   assign status.full       = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `ECFR_ASSERT_NEVER(a_no_overflow, clock, reset, push && status.full, "queue push while full")
   `ECFR_ASSERT_NEVER(a_no_underflow, clock, reset, pop && !status.head_valid, "queue pop while empty")
   `ECFR_ASSERT(a_count_up, clock, reset, push && !pop |=> count_ff == $past(count_ff) + QCNT_W'(1), "queue count did not rise")

endmodule

@@ rtl/core/ecfr_back.sv @@
`include "escaped_crc8_frame_receiver_top_macros.svh"

module ecfr_back
   import ecfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  wr_req_type wr_req,
   input  logic       head_valid,
   input  desc_type   head,
   output logic       pop,
   output logic       rsp_valid,
   output logic [7:0] rsp_frame_counter,
   output logic [7:0] rsp_function_id,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_data,
   output logic       rsp_frame_last
);

   logic [7:0]        frame_store_ff [MEM_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [FILL_W-1:0] slot;
   logic [MEM_AW-1:0] rd_addr;
   logic              issue;
   logic              last;
   logic              valid_ff;
   logic [7:0]        ctr_ff;
   logic [7:0]        fid_ff;
   logic              has_ff;
   logic              last_ff;

   // payload starts after counter and function id
   assign slot    = idx_ff + FILL_W'(2);
   assign rd_addr = {head.bank, slot[ADDR_W-1:0]};
   assign issue   = head_valid;
   assign last    = (head.plen == '0) || (idx_ff + FILL_W'(1) == head.plen);
   assign pop     = issue && last;

   always_comb begin
      idx_in = idx_ff;
      if (issue) begin
         idx_in = last ? '0 : idx_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         frame_store_ff[wr_req.addr] <= wr_req.data;
      end
      if (issue) begin
         rd_data_ff <= frame_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         ctr_ff  <= head.ctr;
         fid_ff  <= head.fid;
         has_ff  <= (head.plen != '0);
         last_ff <= last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_counter = ctr_ff;
   assign rsp_function_id   = fid_ff;
   assign rsp_data_byte     = has_ff ? rd_data_ff : 8'h00;
   assign rsp_has_data      = has_ff;
   assign rsp_frame_last    = last_ff;

   `ECFR_ASSERT_NEVER(a_bank_split, clock, reset, wr_req.en && head_valid && (wr_req.addr[MEM_AW-1] == head.bank), "write into bank being emitted")
   `ECFR_ASSERT(a_empty_is_last, clock, reset, rsp_valid && !rsp_has_data |-> rsp_frame_last, "empty payload result not last")
   `ECFR_ASSERT(a_issue_shows, clock, reset, issue |=> rsp_valid, "issued read gave no result")

endmodule

@@ rtl/core/escaped_crc8_frame_receiver_top.sv @@
// Byte-stuffed frame receiver with CRC-8 check. One raw link word is taken on each
// clock edge where start is high and busy is low. A newline ends a frame; an escape
// word 0xDC makes the next word literal (xor 0x80). Stored words run through an
// MSB-first CRC-8 using the polynomial and start value in the csr registers
// (index 0 polynomial, index 1 start value; other indexes are ignored; csr_ready is
// always high). A frame with zero residue and at least three words yields one result
// per payload word, or one empty result, on rsp_valid for exactly one cycle each;
// the receiver cannot stall the block. Timing: the front end takes one word per
// cycle while busy is low. At a good newline the frame goes to a two-entry queue
// and the back end emits one result per cycle from the frame store read port;
// the queue entry and the read data register lie between the newline and the
// first result. The frame store holds two banks, so the front end keeps filling
// the next frame while the back end emits the last one; busy is high only while
// both banks hold frames waiting to be emitted. Overlong frames (64 words) are
// dropped up to the next raw newline.
module escaped_crc8_frame_receiver_top
   import ecfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input word channel
   input  logic                 start,
   output logic                 busy,
   input  logic [7:0]           req_rx_byte,
   // result channel
   output logic                 rsp_valid,
   output logic [7:0]           rsp_frame_counter,
   output logic [7:0]           rsp_function_id,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_has_data,
   output logic                 rsp_frame_last,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   logic             accept;
   csr_wr_type       csr;
   wr_req_type       wr_req;
   logic             push;
   desc_type         push_desc;
   logic             pop;
   desc_type         head;
   queue_status_type qstat;

   // both banks taken means no room for the next frame
   assign busy      = qstat.full;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign csr.valid = csr_valid && csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   // front end: escape handling, crc, frame store writes, frame check
   ecfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .csr       (csr),
      .wr_req    (wr_req),
      .push      (push),
      .push_desc (push_desc)
   );

   // good frames waiting for emission
   ecfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (qstat)
   );

   // back end: frame store and result sequencing
   ecfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .wr_req            (wr_req),
      .head_valid        (qstat.head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_frame_counter (rsp_frame_counter),
      .rsp_function_id   (rsp_function_id),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_frame_last    (rsp_frame_last)
   );

endmodule

@@ verif/tb_escaped_crc8_frame_receiver_top.sv @@
module tb_escaped_crc8_frame_receiver_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ecfr_pkg::*;

   // indexes past the two real registers, the block must ignore them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   // quiet cycles after the last expected result, long enough to cover anything
   // still in flight
   localparam int TAIL_CYCLES    = 16;
   localparam int MAX_REPORTED   = 10;

   // one result word as the block presents it
   typedef struct packed {
      logic [7:0] counter;
      logic [7:0] func_id;
      logic [7:0] data;
      logic       has_data;
      logic       last;
   } frame_word_type;

   typedef logic [7:0] octet_q_type[$];

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [7:0]           req_rx_byte;
   logic                 rsp_valid;
   logic [7:0]           rsp_frame_counter;
   logic [7:0]           rsp_function_id;
   logic [7:0]           rsp_data_byte;
   logic                 rsp_has_data;
   logic                 rsp_frame_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_wdata;

   escaped_crc8_frame_receiver_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_frame_counter (rsp_frame_counter),
      .rsp_function_id   (rsp_function_id),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_frame_last    (rsp_frame_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // deframer shadow: register copies and front-end state mirrored word by word
   // ---------------------------------------------------------------------------
   logic [7:0]  poly_q;
   logic [7:0]  start_q;
   logic [7:0]  shadow_store [BUF_DEPTH];
   int          shadow_fill;
   logic [7:0]  shadow_crc;
   logic        shadow_escape;
   logic        shadow_dropping;

   // results the block owes us, oldest first
   frame_word_type pending_words[$];

   int          fail_count;
   int          words_sent;
   int          burst_left;

   // msb-first crc-8 over one stored word with the current polynomial
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] v;
      v = acc ^ b;
      repeat (8) begin
         v = v[7] ? ((v << 1) ^ poly_q) : (v << 1);
      end
      return v;
   endfunction

   function automatic string show_word(input frame_word_type w);
      return $sformatf("ctr=%02h fid=%02h data=%02h has_data=%0b last=%0b",
                       w.counter, w.func_id, w.data, w.has_data, w.last);
   endfunction

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTED) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic restart_frame();
      shadow_fill   = 0;
      shadow_escape = 1'b0;
      shadow_crc    = start_q;
   endtask

   // advance the shadow by one accepted raw word and queue any results it releases
   task automatic absorb_rx_word(input logic [7:0] raw);
      logic [7:0]     c;
      frame_word_type w;
      c = raw;
      // overflow recovery: everything up to a raw newline is thrown away
      if (shadow_dropping) begin
         if (c == EOL_BYTE) begin
            shadow_dropping = 1'b0;
            restart_frame();
         end
         return;
      end
      if (!shadow_escape) begin
         if (c == ESC_BYTE) begin
            shadow_escape = 1'b1;
            return;
         end
         if (c == EOL_BYTE) begin
            // good frame: at least counter, id and crc, and a zero residue
            if (shadow_fill >= 3 && shadow_crc == 8'h00) begin
               w.counter = shadow_store[0];
               w.func_id = shadow_store[1];
               if (shadow_fill == 3) begin
                  // no payload: a single empty result word
                  w.data     = 8'h00;
                  w.has_data = 1'b0;
                  w.last     = 1'b1;
                  pending_words.push_back(w);
               end else begin
                  // payload sits between the id and the trailing crc word
                  for (int k = 2; k <= shadow_fill - 2; k++) begin
                     w.data     = shadow_store[k];
                     w.has_data = 1'b1;
                     w.last     = (k == shadow_fill - 2);
                     pending_words.push_back(w);
                  end
               end
            end
            restart_frame();
            return;
         end
      end else begin
         c             = c ^ ESC_FLIP;
         shadow_escape = 1'b0;
      end
      // start value is sampled when the first word of a frame lands
      if (shadow_fill == 0) shadow_crc = start_q;
      shadow_crc = crc8_step(shadow_crc, c);
      shadow_store[shadow_fill] = c;
      shadow_fill++;
      if (shadow_fill >= BUF_DEPTH) begin
         restart_frame();
         shadow_dropping = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------

   // one raw word on the input channel; bursts of random length with random
   // gaps in between, some bursts run back to back with no gap at all
   task automatic send_word(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start       <= 1'b1;
      req_rx_byte <= b;
      // word is taken at the first edge with busy low
      do @(posedge clock); while (busy);
      absorb_rx_word(b);
      words_sent++;
   endtask

   // a stored word on the link: specials and their flipped forms always go out
   // escaped (so escape-newline and escape-escape both occur), others now and then
   task automatic send_stored(input logic [7:0] b);
      if (b == EOL_BYTE || b == ESC_BYTE || b == (EOL_BYTE ^ ESC_FLIP) ||
          b == (ESC_BYTE ^ ESC_FLIP) || $urandom_range(0, 9) == 0) begin
         send_word(ESC_BYTE);
         send_word(b ^ ESC_FLIP);
      end else begin
         send_word(b);
      end
   endtask

   // counter, id and payload, then the crc word that zeroes the residue
   // (optionally spoiled), then the newline
   task automatic send_frame(input octet_q_type body, input logic [7:0] crc_flip);
      logic [7:0] acc;
      acc = start_q;
      foreach (body[i]) begin
         acc = crc8_step(acc, body[i]);
         send_stored(body[i]);
      end
      // crc8(acc, acc) is zero for any polynomial
      send_stored(acc ^ crc_flip);
      send_word(EOL_BYTE);
   endtask

   // extremes and link specials turn up more often than uniform draws give
   function automatic logic [7:0] pick_octet();
      case ($urandom_range(0, 11))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return EOL_BYTE;
         3:       return ESC_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic octet_q_type random_body(input int plen);
      octet_q_type q;
      for (int i = 0; i < plen + 2; i++) q.push_back(pick_octet());
      return q;
   endfunction

   // stop sending, let every owed result arrive, then let the block settle
   task automatic settle_idle();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // register write; valid is left high so back-to-back writes stay clean
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POLY:  poly_q  = val;
         CSR_START: start_q = val;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // short hand-picked set: field extremes, escapes, short and bad-residue rejects
   task automatic test_directed();
      // empty payload with counter and id at opposite extremes
      send_frame({8'h00, 8'hFF}, 8'h00);
      // payload with escaped newline, escaped escape, raw-looking 0x8a and 0x5c
      send_frame({8'hFF, 8'h00, 8'h8A, 8'h5C, EOL_BYTE, ESC_BYTE}, 8'h00);
      // newline on an empty frame, then one- and two-word frames
      send_word(EOL_BYTE);
      send_stored(8'h12);
      send_word(EOL_BYTE);
      send_stored(8'h12);
      send_stored(8'h34);
      send_word(EOL_BYTE);
      // residue off by one bit
      send_frame({8'h55, 8'hAA, 8'h01}, 8'h01);
   endtask

   // store fills up, escapes and junk are skipped until a raw newline,
   // then a normal frame must come through
   task automatic test_overflow();
      logic [7:0] junk;
      for (int i = 0; i < BUF_DEPTH; i++) send_stored(pick_octet());
      junk = pick_octet();
      if (junk == EOL_BYTE) junk = junk ^ 8'h01;
      send_word(ESC_BYTE);
      send_word(junk);
      send_word(ESC_BYTE);
      send_word(EOL_BYTE);
      send_frame(random_body($urandom_range(0, 4)), 8'h00);
   endtask

   // largest frame that fits: 60 payload words
   task automatic test_longest_frame();
      send_frame(random_body(BUF_DEPTH - 4), 8'h00);
   endtask

   // mostly well-formed frames with random content, the rest noise and breakage
   task automatic test_random_traffic(input int target);
      int first;
      int kind;
      int n;
      first = words_sent;
      while (words_sent - first < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            send_frame(random_body(n), 8'h00);
         end else if (kind < 78) begin
            send_frame(random_body($urandom_range(0, 6)), 8'($urandom_range(1, 255)));
         end else if (kind < 86) begin
            // too short to carry counter, id and crc
            n = $urandom_range(0, 2);
            repeat (n) send_stored(pick_octet());
            send_word(EOL_BYTE);
         end else if (kind < 98) begin
            // raw junk, may contain its own escapes and newlines
            n = $urandom_range(1, 8);
            repeat (n) send_word(pick_octet());
            send_word(EOL_BYTE);
         end else begin
            n = $urandom_range(BUF_DEPTH, BUF_DEPTH + 2);
            repeat (n) send_stored(pick_octet());
            send_word(EOL_BYTE);
         end
      end
   endtask

   // new register setting between phases, with the block drained first;
   // writes to the spare indexes go in as well and must change nothing
   task automatic test_config(input logic [7:0] poly, input logic [7:0] init);
      settle_idle();
      write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, 8'($urandom_range(0, 255)));
      write_csr(CSR_POLY, poly);
      write_csr(CSR_START, init);
      write_csr(CSR_SPARE_3, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // result checker: every strobed word is matched against the oldest owed word
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_word_type seen;
      frame_word_type want;
      if (!reset && rsp_valid) begin
         seen = {rsp_frame_counter, rsp_function_id, rsp_data_byte,
                 rsp_has_data, rsp_frame_last};
         if (pending_words.size() == 0) begin
            log_failure($sformatf("unexpected word %s", show_word(seen)));
         end else begin
            want = pending_words.pop_front();
            if (seen !== want) begin
               log_failure($sformatf("expected %s, got %s", show_word(want), show_word(seen)));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      // every input known from time zero
      reset       = 1'b1;
      start       = 1'b0;
      req_rx_byte = 8'h00;
      csr_valid   = 1'b0;
      csr_index   = CSR_POLY;
      csr_wdata   = 8'h00;

      // shadow starts from reset values
      poly_q          = POLY_RESET;
      start_q         = START_RESET;
      shadow_dropping = 1'b0;
      restart_frame();
      fail_count = 0;
      words_sent = 0;
      burst_left = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values first
      test_directed();
      test_overflow();
      test_random_traffic(30);

      // zero polynomial with all-ones start, then the reverse
      test_config(8'h00, 8'hFF);
      test_random_traffic(25);
      test_config(8'hFF, 8'h00);
      test_random_traffic(25);
      test_longest_frame();

      test_config(8'h31, 8'hA5);
      test_random_traffic(25);
      test_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      test_random_traffic(25);
      test_config(8'h1D, 8'hFF);
      test_random_traffic(25);

      // back to the reset setting
      test_config(POLY_RESET, START_RESET);
      test_random_traffic(25);

      settle_idle();
      if (fail_count == 0 && pending_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
